/* hw/rtl/fla_pkg.sv */
// shared types and constants for the free-list page allocator
package fla_pkg;

  localparam int PAGE_W     = 16;
  localparam int CNT_W      = 17;
  localparam int LINK_W     = 17;
  localparam int PAGE_SPACE = 65536;

  localparam int NUM_PAGES_DEF = 65536;

  localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(PAGE_SPACE);
  localparam logic [CNT_W-1:0]  COUNT_MAX  = CNT_W'(PAGE_SPACE);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_ALLOC = 2'd2,
    OP_FREE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page_res;
    logic              ok;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  total_pages;
  } res_t;

endpackage

/* hw/rtl/fla_req_if.sv */
// request and result channel interfaces of the page allocator
interface fla_req_if;
  import fla_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [PAGE_W-1:0] page;
  logic [CNT_W-1:0]  count;

  modport source (output valid, output operation, output page, output count, input ready);
  modport sink   (input valid, input operation, input page, input count, output ready);
endinterface

interface fla_rsp_if;
  import fla_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_res;
  logic              ok;
  logic [CNT_W-1:0]  used_pages;
  logic [CNT_W-1:0]  total_pages;

  modport source (output valid, output page_res, output ok, output used_pages,
                  output total_pages, input ready);
  modport sink   (input valid, input page_res, input ok, input used_pages,
                  input total_pages, output ready);
endinterface

/* hw/rtl/free_list_page_allocator.sv */
// free-list page allocator: lifo list of free pages linked through a next-pointer ram
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+----------------------------------------
//  in_ch    | in  | valid / ready        | operation, page, count
//  out_ch   | out | valid / ready        | page_res, ok, used_pages, total_pages
//
//  clear, free, rejected and empty-list requests finish when accepted, a successful allocate
//  first waits in S_READ for the registered ram read, add region walks the region in S_ADD
//  (one link write a cycle)
//  one transaction is in progress at a time; the result register lets a new request in
//  while the previous result still waits, stalling only when a second result is ready
//  synchronous active-low reset empties the list and zeroes both counts; the link ram
//  is not cleared, since no entry is read before it has been written
module free_list_page_allocator #(
  parameter int NUM_PAGES = fla_pkg::NUM_PAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fla_req_if.sink   in_ch,
  fla_rsp_if.source out_ch
);
  import fla_pkg::*;

  // ram covers the page numbers that can ever be pushed
  localparam int MEM_DEPTH = (NUM_PAGES < PAGE_SPACE) ? NUM_PAGES : PAGE_SPACE;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam logic [CNT_W:0] PAGE_LIMIT = (CNT_W+1)'(MEM_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ADD  = 4'b0100,
    S_RES  = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    total_r, total_nxt;
  logic [ADDR_W-1:0]   walk_pg_r, walk_pg_nxt;
  logic [CNT_W-1:0]    walk_left_r, walk_left_nxt;
  res_t                pend_r, out_res_r;
  logic                out_valid_r;

  logic                in_acc;
  op_t                 in_op;
  logic                slot_free;
  logic                fin;
  res_t                fin_res;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [LINK_W-1:0]   ram_rdata;
  logic [CNT_W:0]      region_end;
  logic                region_ok;
  logic [CNT_W:0]      total_sum;
  logic [CNT_W-1:0]    total_sat;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.operation);

  // output register is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ch.ready;

  // region must end at or below the page limit
  assign region_end = (CNT_W+1)'(in_ch.page) + (CNT_W+1)'(in_ch.count);
  assign region_ok  = (region_end <= PAGE_LIMIT);

  // total count saturates at the size of the page space
  assign total_sum = (CNT_W+1)'(total_r) + (CNT_W+1)'(in_ch.count);
  assign total_sat = (total_sum > (CNT_W+1)'(COUNT_MAX)) ? COUNT_MAX : total_sum[CNT_W-1:0];

  fla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MEM_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (head_r),
    .rd_addr (head_r[ADDR_W-1:0]),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    walk_pg_nxt   = walk_pg_r;
    walk_left_nxt = walk_left_r;
    fin           = 1'b0;
    fin_res       = '0;
    ram_we        = 1'b0;
    ram_waddr     = in_ch.page[ADDR_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_CLEAR: begin
              head_nxt   = EMPTY_MARK;
              used_nxt   = '0;
              total_nxt  = '0;
              fin        = 1'b1;
              fin_res.ok = 1'b1;
            end
            OP_ADD: begin
              if (region_ok) begin
                total_nxt = total_sat;
                if (in_ch.count == '0) begin
                  fin        = 1'b1;
                  fin_res.ok = 1'b1;
                end else begin
                  // walk the region, lowest page first
                  state_nxt     = S_ADD;
                  walk_pg_nxt   = in_ch.page[ADDR_W-1:0];
                  walk_left_nxt = in_ch.count;
                end
              end else begin
                fin = 1'b1;
              end
            end
            OP_ALLOC: begin
              if (head_r[LINK_W-1]) begin
                // empty list
                fin = 1'b1;
              end else begin
                // link ram is read at the head this cycle
                state_nxt = S_READ;
              end
            end
            OP_FREE: begin
              if (in_ch.page != '0 && (CNT_W+1)'(in_ch.page) < PAGE_LIMIT) begin
                ram_we     = 1'b1;
                head_nxt   = LINK_W'(in_ch.page[ADDR_W-1:0]);
                used_nxt   = (used_r != '0) ? used_r - 1'b1 : used_r;
                fin_res.ok = 1'b1;
              end
              fin = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // pop the head; a link past the marker can only be an unwritten entry
        head_nxt         = (ram_rdata > EMPTY_MARK) ? EMPTY_MARK : ram_rdata;
        used_nxt         = (used_r < COUNT_MAX) ? used_r + 1'b1 : used_r;
        fin              = 1'b1;
        fin_res.ok       = 1'b1;
        fin_res.page_res = head_r[PAGE_W-1:0];
      end
      S_ADD: begin
        ram_we        = 1'b1;
        ram_waddr     = walk_pg_r;
        head_nxt      = LINK_W'(walk_pg_r);
        walk_pg_nxt   = walk_pg_r + 1'b1;
        walk_left_nxt = walk_left_r - 1'b1;
        if (walk_left_r == CNT_W'(1)) begin
          fin        = 1'b1;
          fin_res.ok = 1'b1;
        end
      end
      S_RES: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    fin_res.used_pages  = used_nxt;
    fin_res.total_pages = total_nxt;

    // park the result when the output register is still occupied
    if (fin) begin
      state_nxt = slot_free ? S_IDLE : S_RES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= EMPTY_MARK;
      used_r      <= '0;
      total_r     <= '0;
      walk_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      walk_left_r <= walk_left_nxt;
      if ((fin || state_r == S_RES) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    walk_pg_r <= walk_pg_nxt;
    if (fin && !slot_free) begin
      pend_r <= fin_res;
    end
    if (slot_free) begin
      if (state_r == S_RES) begin
        out_res_r <= pend_r;
      end else if (fin) begin
        out_res_r <= fin_res;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.page_res    = out_res_r.page_res;
  assign out_ch.ok          = out_res_r.ok;
  assign out_ch.used_pages  = out_res_r.used_pages;
  assign out_ch.total_pages = out_res_r.total_pages;

  // a parked result always sits behind a valid output
  a_parked_behind_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RES |-> out_valid_r)
    else $error("parked result without a valid output");

  // the head is a page number or the empty marker
  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= EMPTY_MARK)
    else $error("list head beyond empty marker");

  // an allocate on a non-empty list enters S_READ in the next cycle to wait for the link
  a_alloc_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_op == OP_ALLOC && !head_r[LINK_W-1] |=> state_r == S_READ)
    else $error("allocate did not wait for link read");

  // the region walk never runs with nothing left to push
  a_walk_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ADD |-> walk_left_r != '0)
    else $error("region walk with zero pages left");

endmodule

/* hw/rtl/fla_ram.sv */
// generic simple dual-port ram with registered read
module fla_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
